/* hdl/btl_pkg.sv */
// Shared types and constants for the byte trie lookup/insert block.
// Used by btl_controller, btl_datapath and byte_trie_lookup_insert.
package btl_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int MAX_KEY_BYTES = 8;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int FREE_W  = NODE_W + 1;
    localparam int LINK_AW = NODE_W + 8;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int CNT_W   = 4;
    localparam int REQ_W   = 2;

    localparam logic [REQ_W-1:0] REQ_POINT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FULL,
        RES_VALUE
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      walk;
        logic      clr_en;
        logic      set_wr;
        logic      load_out;
        res_kind_t res;
    } btl_cmd_t;

    typedef struct packed {
        logic levels_zero;
        logic walk_full;
        logic walk_last;
        logic clr_last;
        logic out_free;
    } btl_stat_t;

endpackage

/* hdl/btl_controller.sv */
// Sequencer for the byte trie: clearing pass, key walk, value read, response.
// Depends on btl_pkg; drives btl_datapath through btl_cmd_t.
module btl_controller import btl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [REQ_W-1:0] req_type,
    input  btl_stat_t        stat,
    output logic             req_stall,
    output btl_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_VWAIT,
        S_RESULT
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t res_reg, res_next;
    logic      clr_rsp_reg, clr_rsp_next;

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        clr_rsp_next = clr_rsp_reg;
        cmd          = '0;
        cmd.res      = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    res_next     = RES_ZERO;
                    clr_rsp_next = 1'b0;
                    state_next   = clr_rsp_reg ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next = RES_ZERO;
                    case (req_type)
                        REQ_POINT:
                        begin
                            cmd.capture = 1'b1;
                            res_next    = RES_VALUE;
                            state_next  = stat.levels_zero ? S_VWAIT : S_WALK;
                        end
                        REQ_SET:
                        begin
                            cmd.set_wr = 1'b1;
                            state_next = S_RESULT;
                        end
                        REQ_CLEAR:
                        begin
                            clr_rsp_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_full)
                begin
                    res_next   = RES_FULL;
                    state_next = S_RESULT;
                end
                else if (stat.walk_last)
                begin
                    state_next = S_VWAIT;
                end
            end
            S_VWAIT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            res_reg     <= RES_ZERO;
            clr_rsp_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            clr_rsp_reg <= clr_rsp_next;
        end
    end

endmodule

/* hdl/btl_datapath.sv */
// Datapath for the byte trie: link and value memories, walk registers,
// free-node index, selected entry and response register. Depends on btl_pkg.
module btl_datapath import btl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  btl_cmd_t         cmd,
    input  logic [KEY_W-1:0] key,
    input  logic [CNT_W-1:0] key_bytes,
    input  logic [VAL_W-1:0] value,
    input  logic             rsp_stall,
    output btl_stat_t        stat,
    output logic             rsp_valid,
    output logic [VAL_W-1:0] content_value,
    output logic             status
);

    logic [NODE_W-1:0]  link_mem [MAX_NODES*256];
    logic [VAL_W-1:0]   val_mem  [MAX_NODES];

    logic [KEY_W-1:0]   key_sh_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LINK_AW-1:0] addr_reg;
    logic [NODE_W-1:0]  link_rdata_reg;
    logic [VAL_W-1:0]   val_rdata_reg;
    logic [FREE_W-1:0]  next_free_reg;
    logic [NODE_W-1:0]  sel_reg;
    logic [LINK_AW-1:0] clr_reg;
    logic               rsp_valid_reg;
    logic [VAL_W-1:0]   content_reg;
    logic               status_reg;

    logic [CNT_W-1:0]   levels_in;
    logic               link_zero;
    logic               fresh_ok;
    logic [FREE_W-1:0]  fresh_inc;
    logic               walk_full;
    logic               walk_last;
    logic [NODE_W-1:0]  nxt_node;
    logic               walk_step;
    logic               walk_end;

    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    logic [NODE_W-1:0]  link_wdata;
    logic               link_re;
    logic [LINK_AW-1:0] link_raddr;

    logic               val_we;
    logic [NODE_W-1:0]  val_waddr;
    logic [VAL_W-1:0]   val_wdata;
    logic               val_re;
    logic [NODE_W-1:0]  val_raddr;

    assign levels_in = (key_bytes > CNT_W'(MAX_KEY_BYTES)) ? CNT_W'(MAX_KEY_BYTES) : key_bytes;

    assign link_zero = (link_rdata_reg == '0);
    assign fresh_ok  = (next_free_reg < FREE_W'(MAX_NODES));
    assign fresh_inc = next_free_reg + 1'b1;
    assign walk_full = link_zero && (!fresh_ok || (fresh_inc >= FREE_W'(MAX_NODES)));
    assign walk_last = (cnt_reg == CNT_W'(1));
    assign nxt_node  = link_zero ? next_free_reg[NODE_W-1:0] : link_rdata_reg;
    assign walk_step = cmd.walk && !walk_full && !walk_last;
    assign walk_end  = cmd.walk && !walk_full && walk_last;

    assign stat.levels_zero = (levels_in == '0);
    assign stat.walk_full   = walk_full;
    assign stat.walk_last   = walk_last;
    assign stat.clr_last    = &clr_reg;
    assign stat.out_free    = !rsp_valid_reg || !rsp_stall;

    // link memory: clear sweep or fill of an empty link; read of next level
    assign link_we    = cmd.clr_en || (cmd.walk && link_zero && fresh_ok);
    assign link_waddr = cmd.clr_en ? clr_reg : addr_reg;
    assign link_wdata = cmd.clr_en ? '0 : next_free_reg[NODE_W-1:0];
    assign link_re    = cmd.capture || walk_step;
    assign link_raddr = cmd.capture ? {NODE_W'(0), key[7:0]} : {nxt_node, key_sh_reg[15:8]};

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        if (link_re)
            link_rdata_reg <= link_mem[link_raddr];
    end

    assign val_we    = cmd.clr_en || cmd.set_wr;
    assign val_waddr = cmd.clr_en ? clr_reg[NODE_W-1:0] : sel_reg;
    assign val_wdata = cmd.clr_en ? '0 : value;
    assign val_re    = (cmd.capture && stat.levels_zero) || walk_end;
    assign val_raddr = cmd.capture ? '0 : nxt_node;

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[val_waddr] <= val_wdata;
        if (val_re)
            val_rdata_reg <= val_mem[val_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_sh_reg <= key;
            cnt_reg    <= levels_in;
            addr_reg   <= link_raddr;
        end
        else if (walk_step)
        begin
            key_sh_reg <= {8'd0, key_sh_reg[KEY_W-1:8]};
            cnt_reg    <= cnt_reg - 1'b1;
            addr_reg   <= link_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= FREE_W'(1);
            sel_reg       <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                next_free_reg <= FREE_W'(1);
                clr_reg       <= clr_reg + 1'b1;
            end
            else if (cmd.walk && link_zero && fresh_ok)
            begin
                next_free_reg <= fresh_inc;
            end
            if (val_re)
                sel_reg <= val_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.load_out)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.res)
                RES_VALUE: content_reg <= val_rdata_reg;
                RES_FULL:  content_reg <= '1;
                default:   content_reg <= '0;
            endcase
            status_reg <= (cmd.res == RES_FULL);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign content_value = content_reg;
    assign status        = status_reg;

endmodule

/* hdl/byte_trie_lookup_insert.sv */
// Channel  Handshake             Payload
// req      req_valid/req_stall   req_type, key, key_bytes, value
// rsp      rsp_valid/rsp_stall   content_value, status
//
// Point request: accept, one link-memory read per level, value read, response load.
// key_bytes above MAX_KEY_BYTES counts as MAX_KEY_BYTES; a pool-full walk ends at that level.
// Set and ignored request types go straight to the response; a clear sweeps the link memory first.
// After reset the link memory is swept once with req_stall high.
// One transaction at a time; a new request is taken while the last response is held,
// and a stalled response holds the next one in the controller's result state.
// Top level of the byte trie; depends on btl_pkg, btl_controller, btl_datapath.
module byte_trie_lookup_insert import btl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [REQ_W-1:0] req_type,
    input  logic [KEY_W-1:0] key,
    input  logic [CNT_W-1:0] key_bytes,
    input  logic [VAL_W-1:0] value,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [VAL_W-1:0] content_value,
    output logic             status
);

    btl_cmd_t  cmd;
    btl_stat_t stat;

    btl_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .stat      (stat),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    btl_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .key           (key),
        .key_bytes     (key_bytes),
        .value         (value),
        .rsp_stall     (rsp_stall),
        .stat          (stat),
        .rsp_valid     (rsp_valid),
        .content_value (content_value),
        .status        (status)
    );

endmodule

/* hdl/btl_checker.sv */
// Port-level checks for byte_trie_lookup_insert, attached by bind.
// Depends on btl_pkg.
module btl_checker import btl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input logic [VAL_W-1:0] content_value,
    input logic             status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(content_value) && $stable(status))
        else $error("response payload changed while stalled");

    a_full_ones: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> (content_value == '1))
        else $error("pool-full response without all-ones value");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second transaction taken before first completed");

endmodule

bind byte_trie_lookup_insert btl_checker u_btl_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .content_value (content_value),
    .status        (status)
);

/* verif/tb.sv */
// Self-checking testbench for byte_trie_lookup_insert: a directed table, then random
// point/set/clear/ignored traffic, checked against typed table responses or a trie predictor.
// Depends on btl_pkg and the byte_trie_lookup_insert RTL.
`timescale 1ns / 1ps

module tb;
    import btl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
    localparam logic [VAL_W-1:0] ALL_ONES    = '1;
    localparam int               WD_LIMIT    = 4 * MAX_NODES * 256;
    localparam int               ITEM_TARGET = 1550;

    typedef struct packed {
        logic [REQ_W-1:0] rtype;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] nbytes;
        logic [VAL_W-1:0] value;
    } trie_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] content;
        logic             full;
    } trie_rsp_t;

    typedef struct packed {
        trie_req_t req;
        bit        typed;
        trie_rsp_t rsp;
    } dir_row_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] nbytes;
    } key_ref_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    logic [REQ_W-1:0] req_type  = REQ_POINT;
    logic [KEY_W-1:0] key       = '0;
    logic [CNT_W-1:0] key_bytes = '0;
    logic [VAL_W-1:0] value     = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    logic [VAL_W-1:0] content_value;
    logic             status;

    // trie predictor state
    bit [NODE_W-1:0]  trie_links [int];
    logic [VAL_W-1:0] node_values [MAX_NODES];
    int unsigned      free_node;
    int unsigned      cur_entry;

    trie_rsp_t pending_rsp [$];
    key_ref_t  known_keys [$];
    dir_row_t  dir_tbl [];

    int err_cnt     = 0;
    int sent_cnt    = 0;
    int useful_cnt  = 0;
    int checked_cnt = 0;
    int full_cnt    = 0;
    int clear_cnt   = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int seg_left    = 0;
    int stall_mode  = 0;

    byte_trie_lookup_insert i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .key           (key),
        .key_bytes     (key_bytes),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .content_value (content_value),
        .status        (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void wipe_trie_model();
        trie_links.delete();
        foreach (node_values[i])
        begin
            node_values[i] = '0;
        end
        free_node = 1;
    endfunction

    function automatic trie_rsp_t trie_model(input trie_req_t r);
        trie_rsp_t   o;
        int unsigned node;
        int unsigned levels;
        int unsigned slot;
        int unsigned fresh;
        bit          ran_out;
        o = '0;
        case (r.rtype)
            REQ_POINT:
            begin
                levels  = (r.nbytes > MAX_KEY_BYTES) ? MAX_KEY_BYTES : r.nbytes;
                node    = 0;
                ran_out = 1'b0;
                for (int d = 0; d < levels && !ran_out; d++)
                begin
                    slot = node * 256 + r.key[8*d +: 8];
                    if (trie_links.exists(slot))
                    begin
                        node = trie_links[slot];
                    end
                    else
                    begin
                        fresh = free_node;
                        if (fresh >= MAX_NODES)
                        begin
                            ran_out = 1'b1;
                        end
                        else
                        begin
                            trie_links[slot] = fresh[NODE_W-1:0];
                            free_node = fresh + 1;
                            if (fresh + 1 >= MAX_NODES)
                            begin
                                ran_out = 1'b1;
                            end
                            node = fresh;
                        end
                    end
                end
                if (ran_out)
                begin
                    o.content = ALL_ONES;
                    o.full    = 1'b1;
                end
                else
                begin
                    cur_entry = node;
                    o.content = node_values[node];
                end
            end
            REQ_SET:
            begin
                node_values[cur_entry] = r.value;
            end
            REQ_CLEAR:
            begin
                wipe_trie_model();
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic dir_row_t mk_row(input logic [REQ_W-1:0] t, input logic [KEY_W-1:0] k,
                                        input logic [CNT_W-1:0] nb, input logic [VAL_W-1:0] v,
                                        input bit typed, input logic [VAL_W-1:0] c,
                                        input logic f);
        dir_row_t row;
        row.req   = '{rtype: t, key: k, nbytes: nb, value: v};
        row.typed = typed;
        row.rsp   = '{content: c, full: f};
        return row;
    endfunction

    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] rand_depth();
        if ($urandom_range(0, 9) == 0)
        begin
            return CNT_W'($urandom_range(9, 15));
        end
        return CNT_W'($urandom_range(1, 8));
    endfunction

    // one request transaction, then the sender's burst/gap pacing
    task automatic send_one(input trie_req_t r, input bit typed, input trie_rsp_t typed_rsp);
        trie_rsp_t p;
        req_valid <= 1'b1;
        req_type  <= r.rtype;
        key       <= r.key;
        key_bytes <= r.nbytes;
        value     <= r.value;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        p = trie_model(r);
        pending_rsp.push_back(typed ? typed_rsp : p);
        full_cnt += p.full;
        sent_cnt++;
        if (r.rtype != REQ_IGNORED)
        begin
            useful_cnt++;
        end
        if (r.rtype == REQ_CLEAR)
        begin
            clear_cnt++;
        end
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    endtask

    task automatic send_req(input logic [REQ_W-1:0] t, input logic [KEY_W-1:0] k,
                            input logic [CNT_W-1:0] nb, input logic [VAL_W-1:0] v);
        send_one('{rtype: t, key: k, nbytes: nb, value: v}, 1'b0, '0);
    endtask

    task automatic run_random(input int target);
        int               pick;
        key_ref_t         kr;
        logic [KEY_W-1:0] k;
        logic [CNT_W-1:0] nb;
        while (useful_cnt < target)
        begin
            pick = $urandom_range(0, 99);
            if (known_keys.size() == 0 || pick < 40)
            begin
                k  = {$urandom, $urandom};
                nb = rand_depth();
                known_keys.push_back('{key: k, nbytes: nb});
                if (known_keys.size() > 64)
                begin
                    void'(known_keys.pop_front());
                end
                send_req(REQ_POINT, k, nb, rand_word());
                send_req(REQ_SET, rand_word(), rand_depth(), rand_word());
                send_req(REQ_POINT, k, nb, rand_word());
            end
            else if (pick < 65)
            begin
                kr = known_keys[$urandom_range(0, known_keys.size() - 1)];
                send_req(REQ_POINT, kr.key, kr.nbytes, rand_word());
                if ($urandom_range(0, 1))
                begin
                    send_req(REQ_SET, rand_word(), rand_depth(), rand_word());
                end
            end
            else if (pick < 75)
            begin
                // shared prefix, new branch further down
                kr = known_keys[$urandom_range(0, known_keys.size() - 1)];
                k  = kr.key ^ ({$urandom, $urandom} << (8 * $urandom_range(1, 7)));
                send_req(REQ_POINT, k, 4'd8, rand_word());
            end
            else if (pick < 85)
            begin
                send_req(REQ_POINT, {$urandom, $urandom}, CNT_W'($urandom_range(0, 15)),
                         rand_word());
            end
            else if (pick < 90)
            begin
                send_req(REQ_SET, {$urandom, $urandom}, CNT_W'($urandom_range(0, 15)),
                         rand_word());
            end
            else if (pick < 95)
            begin
                send_req(REQ_IGNORED, {$urandom, $urandom}, CNT_W'($urandom_range(0, 15)),
                         rand_word());
            end
            else
            begin
                send_req(REQ_POINT, {$urandom, $urandom}, 4'd0, rand_word());
                send_req(REQ_SET, {$urandom, $urandom}, 4'd0, rand_word());
            end
        end
    endtask

    // receiver stall pattern: segments of differing stall density
    always @(negedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_left   <= $urandom_range(10, 60);
            stall_mode <= $urandom_range(0, 3);
            rsp_stall  <= 1'b0;
        end
        else
        begin
            seg_left <= seg_left - 1;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= 1'($urandom_range(0, 1));
                2:       rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= ((seg_left % 8) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        trie_rsp_t exp_rsp;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                begin
                    $display("%t unexpected response: content_value=%h status=%b",
                             $realtime, content_value, status);
                end
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                checked_cnt++;
                if (content_value !== exp_rsp.content || status !== exp_rsp.full)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("%t mismatch: content_value exp %h got %h, status exp %b got %b",
                                 $realtime, exp_rsp.content, content_value, exp_rsp.full,
                                 status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("byte_trie_lookup_insert regression: fail");
            $finish;
        end
    end

    initial
    begin
        dir_tbl = '{
            mk_row(REQ_POINT, 64'h0, 4'd0, 64'h0, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_SET, 64'h0, 4'd0, ALL_ONES, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h0, 4'd0, 64'h0, 1'b1, ALL_ONES, 1'b0),
            mk_row(REQ_POINT, ALL_ONES, 4'd8, 64'h0, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_SET, 64'h0, 4'd8, 64'h0123_4567_89ab_cdef, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, ALL_ONES, 4'd15, ALL_ONES, 1'b1, 64'h0123_4567_89ab_cdef, 1'b0),
            mk_row(REQ_POINT, 64'hff, 4'd1, 64'h0, 1'b0, 64'h0, 1'b0),
            mk_row(REQ_SET, ALL_ONES, 4'd15, 64'h0, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_IGNORED, ALL_ONES, 4'd15, ALL_ONES, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h0, 4'd8, 64'h0, 1'b0, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h8000_0000_0000_0001, 4'd8, 64'h0, 1'b0, 64'h0, 1'b0),
            mk_row(REQ_SET, 64'h0, 4'd0, 64'h8000_0000_0000_0000, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h8000_0000_0000_0001, 4'd8, 64'h0, 1'b0, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h5a5a_5a5a_5a5a_5a5a, 4'd4, 64'h0, 1'b0, 64'h0, 1'b0),
            mk_row(REQ_SET, 64'h0, 4'd0, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h0000_0000_5a5a_5a5a, 4'd12, 64'h0, 1'b0, 64'h0, 1'b0),
            mk_row(REQ_CLEAR, ALL_ONES, 4'd15, ALL_ONES, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, ALL_ONES, 4'd8, 64'h0, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h0, 4'd0, 64'h0, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_SET, 64'h0, 4'd0, 64'h5555_5555_5555_5555, 1'b1, 64'h0, 1'b0),
            mk_row(REQ_POINT, 64'h1234, 4'd0, 64'h0, 1'b0, 64'h0, 1'b0)
        };
        wipe_trie_model();
        cur_entry = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tbl[i])
        begin
            send_one(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].rsp);
        end

        // first half fills the node pool, then a clear, then a fresh pool
        run_random(ITEM_TARGET / 2);
        send_req(REQ_CLEAR, {$urandom, $urandom}, CNT_W'($urandom_range(0, 15)), rand_word());
        known_keys.delete();
        run_random(ITEM_TARGET);

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        $display("covered %0d transactions (%0d point/set/clear), %0d responses checked",
                 sent_cnt, useful_cnt, checked_cnt);
        $display("pool-full answers: %0d, clears: %0d, mismatches: %0d",
                 full_cnt, clear_cnt, err_cnt);
        if (err_cnt == 0)
        begin
            $display("byte_trie_lookup_insert regression: pass");
        end
        else
        begin
            $display("byte_trie_lookup_insert regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/btl_pkg.sv
hdl/btl_controller.sv
hdl/btl_datapath.sv
hdl/byte_trie_lookup_insert.sv
hdl/btl_checker.sv
verif/tb.sv
